// ----- rtl/core/countdown_timer_slot_table_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the countdown timer slot table
// Wrappers for concurrent assertions. They are clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_SLOT_TABLE_MACROS_SVH
`define COUNTDOWN_TIMER_SLOT_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge.
`define CTST_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ctst assertion failed");
// Condition in one cycle implies a consequence in the next.
`define CTST_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("ctst assertion failed");
`else
`define CTST_ASSERT(lbl, clk, rst_n, prop)
`define CTST_ASSERT_NEXT(lbl, clk, rst_n, cond, cons)
`endif

`endif

// ----- rtl/core/ctst_pkg.sv -----
// ----------------------------------------------------------------------------
// Countdown timer slot table package
// Sizes, action and result codes, item and chain types.
// ----------------------------------------------------------------------------
package ctst_pkg;

	// table size and result limit
	localparam int SLOTS   = 16;
	localparam int MAX_RES = 16;
	localparam int CNT_W   = $clog2(MAX_RES + 1);

	// field widths
	localparam int SEC_W  = 16;
	localparam int TAG_W  = 8;
	localparam int SLOT_W = 4;
	localparam int KIND_W = 2;

	// action codes
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

	// command item
	typedef struct packed {
		logic             action;
		logic [SEC_W-1:0] seconds;
		logic [TAG_W-1:0] tag;
	} cmd_item_t;

	// result item
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  expired_tag;
		logic              last;
	} rsp_item_t;

	// token that walks down the cell chain, one cell per step
	typedef struct packed {
		logic             valid;
		logic             action;
		logic [SEC_W-1:0] seconds;
		logic [TAG_W-1:0] tag;
		logic             claimed;
	} token_t;

	// event raised by the cell that holds the token
	typedef struct packed {
		logic              hit;
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  tag;
	} event_t;

endpackage

// ----- rtl/core/ctst_cell.sv -----
// ----------------------------------------------------------------------------
// Timer slot cell
// Holds one timer slot and processes the token while it passes through.
// ----------------------------------------------------------------------------
module ctst_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [ctst_pkg::SLOT_W-1:0] slot,
	input  ctst_pkg::token_t         tok_in,
	output ctst_pkg::token_t         tok_out,
	output ctst_pkg::event_t         ev
);
	import ctst_pkg::*;

	token_t           tok_q;
	logic             busy_q;
	logic [SEC_W-1:0] rem_q;
	logic [TAG_W-1:0] tag_q;

	logic work;
	logic claim;
	logic expire;
	logic count;

	// decisions for the token held here
	assign work   = tok_q.valid;
	assign claim  = work && (tok_q.action == ACT_ADD) && !tok_q.claimed && !busy_q;
	assign expire = work && (tok_q.action == ACT_TICK) && busy_q && (rem_q <= tok_q.seconds);
	assign count  = work && (tok_q.action == ACT_TICK) && busy_q && !expire;

	// pass the token on, marked if this slot was claimed
	always_comb begin
		tok_out         = tok_q;
		tok_out.claimed = tok_q.claimed | claim;
	end

	// event toward the controller, all zero unless this cell hits
	always_comb begin
		ev = '0;
		if (claim || expire) begin
			ev.hit  = 1'b1;
			ev.kind = claim ? KIND_ADDED : KIND_EXPIRED;
			ev.slot = slot;
			ev.tag  = expire ? tag_q : '0;
		end
	end

	// token stage and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			busy_q <= 1'b0;
		end else if (step) begin
			tok_q <= tok_in;
			if (claim) begin
				busy_q <= 1'b1;
			end else if (expire) begin
				busy_q <= 1'b0;
			end
		end
	end

	// timer payload
	always_ff @(posedge clk) begin
		if (step) begin
			if (claim) begin
				rem_q <= tok_q.seconds;
				tag_q <= tok_q.tag;
			end else if (count) begin
				rem_q <= rem_q - tok_q.seconds;
			end
		end
	end

endmodule

// ----- rtl/core/ctst_ctrl.sv -----
// ----------------------------------------------------------------------------
// Timer table controller
// Injects command tokens, collects cell events and issues result items.
// ----------------------------------------------------------------------------
`include "countdown_timer_slot_table_macros.svh"

module ctst_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  ctst_pkg::cmd_item_t  cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output ctst_pkg::rsp_item_t  rsp,
	input  ctst_pkg::event_t     ev,
	input  logic                 tail_valid,
	output logic                 step,
	output ctst_pkg::token_t     tok_head
);
	import ctst_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]       state_q;
	logic             op_q;
	logic [CNT_W-1:0] n_q;
	logic             held_valid_q;
	event_t           held_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	logic      take;
	logic      rsp_free;
	logic      keep_ev;
	logic      push;
	rsp_item_t push_item;

	assign take      = cmd_valid && (state_q == ST_IDLE);
	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// chain moves unless a new event needs the held one pushed into a full output
	assign step    = !(ev.hit && held_valid_q && !rsp_free);
	assign keep_ev = (state_q == ST_RUN) && step && ev.hit && (n_q < CNT_W'(MAX_RES));

	// new token for the head of the chain
	always_comb begin
		tok_head.valid   = take;
		tok_head.action  = cmd.action;
		tok_head.seconds = cmd.seconds;
		tok_head.tag     = cmd.tag;
		tok_head.claimed = 1'b0;
	end

	// result selection: displaced held event, or the closing result
	always_comb begin
		push      = 1'b0;
		push_item = '0;
		case (state_q)
			ST_RUN: begin
				if (keep_ev && held_valid_q) begin
					push                  = 1'b1;
					push_item.kind        = held_q.kind;
					push_item.slot        = held_q.slot;
					push_item.expired_tag = held_q.tag;
					push_item.last        = 1'b0;
				end
			end
			ST_FINISH: begin
				if (rsp_free) begin
					push = 1'b1;
					if (held_valid_q) begin
						push_item.kind        = held_q.kind;
						push_item.slot        = held_q.slot;
						push_item.expired_tag = held_q.tag;
					end else begin
						push_item.kind = (op_q == ACT_ADD) ? KIND_FULL : KIND_NONE;
					end
					push_item.last = 1'b1;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			held_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						n_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (keep_ev) begin
						held_valid_q <= 1'b1;
						n_q          <= n_q + CNT_W'(1);
					end
					if (step && tail_valid) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (rsp_free) begin
						held_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			op_q <= cmd.action;
		end
		if (keep_ev) begin
			held_q <= ev;
		end
		if (push) begin
			rsp_q <= push_item;
		end
	end

	// a held event only exists while an item is in progress
	`CTST_ASSERT(a_held_busy, clk, arst_n, !held_valid_q || (state_q != ST_IDLE))
	// the closing result always carries last
	`CTST_ASSERT_NEXT(a_finish_last, clk, arst_n, (state_q == ST_FINISH) && !rsp_stall, rsp_valid_q && rsp_q.last)
	// stored result count never passes the limit
	`CTST_ASSERT(a_count_limit, clk, arst_n, n_q <= CNT_W'(MAX_RES))

endmodule

// ----- rtl/core/countdown_timer_slot_table.sv -----
// Results: the closing result is registered after the token has passed the last slot cell;
// on a tick, each earlier expiry leaves when the token finds the next one behind it.
// Items: a new item is accepted only once the previous closing result is issued; the token walks
// one cell per cycle, and a stalled output holds the chain when a further expiry is found.
// Reset: arst_n clears all busy flags, the chain and the output; slot data is loaded on add.
// ----------------------------------------------------------------------------
// Countdown timer slot table
// Row of timer cells walked by a command token, with a result controller.
// ----------------------------------------------------------------------------
`include "countdown_timer_slot_table_macros.svh"

module countdown_timer_slot_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  ctst_pkg::cmd_item_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ctst_pkg::rsp_item_t rsp
);
	import ctst_pkg::*;

	token_t           tok_arr [SLOTS+1];
	event_t           ev_arr  [SLOTS];
	event_t           ev_all;
	logic [SLOTS-1:0] tok_vld;
	logic             step;

	ctst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.ev        (ev_all),
		.tail_valid(tok_arr[SLOTS].valid),
		.step      (step),
		.tok_head  (tok_arr[0])
	);

	// chain of slot cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		ctst_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.slot   (SLOT_W'(i)),
			.tok_in (tok_arr[i]),
			.tok_out(tok_arr[i+1]),
			.ev     (ev_arr[i])
		);
	end

	// only the cell holding the token raises an event
	always_comb begin
		ev_all = '0;
		for (int i = 0; i < SLOTS; i++) begin
			ev_all = ev_all | ev_arr[i];
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			tok_vld[i] = tok_arr[i+1].valid;
		end
	end

	// never more than one token in the chain
	`CTST_ASSERT(a_one_token, clk, arst_n, $onehot0(tok_vld))

endmodule

// ----- dv/countdown_timer_slot_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Countdown timer slot table testbench
// Drives add and tick items into the timer table under varying idle mixes on
// both channels. A scoreboard keeps its own copy of the slot table and checks
// every result item in order against its prediction.
// ----------------------------------------------------------------------------
module countdown_timer_slot_table_tb;
	import ctst_pkg::*;

	class timer_table_scoreboard;
		bit               busy[SLOTS];
		logic [SEC_W-1:0] remaining[SLOTS];
		logic [TAG_W-1:0] owner_tag[SLOTS];
		rsp_item_t        expected_q[$];
		int               errors;
		int               cmd_count;
		int               rsp_count;
		int               expiry_count;
		int               full_count;

		// apply one accepted command to the table and queue its results
		function void note_cmd(cmd_item_t c);
			rsp_item_t r;
			rsp_item_t fired[$];
			bit        claimed;
			claimed = 1'b0;
			cmd_count++;
			if (c.action == ACT_ADD) begin
				r      = '0;
				r.kind = KIND_FULL;
				r.last = 1'b1;
				// lowest free slot wins
				for (int i = 0; i < SLOTS && !claimed; i++) begin
					if (!busy[i]) begin
						busy[i]      = 1'b1;
						remaining[i] = c.seconds;
						owner_tag[i] = c.tag;
						r.kind       = KIND_ADDED;
						r.slot       = SLOT_W'(i);
						claimed      = 1'b1;
					end
				end
				if (!claimed)
					full_count++;
				expected_q.push_back(r);
			end else begin
				// saturating countdown, expiries in slot order
				for (int i = 0; i < SLOTS; i++) begin
					if (busy[i]) begin
						remaining[i] = (remaining[i] > c.seconds) ?
							remaining[i] - c.seconds : '0;
						if (remaining[i] == '0) begin
							busy[i] = 1'b0;
							if (fired.size() < MAX_RES) begin
								r             = '0;
								r.kind        = KIND_EXPIRED;
								r.slot        = SLOT_W'(i);
								r.expired_tag = owner_tag[i];
								fired.push_back(r);
							end
						end
					end
				end
				expiry_count += fired.size();
				if (fired.size() == 0) begin
					r      = '0;
					r.kind = KIND_NONE;
					r.last = 1'b1;
					expected_q.push_back(r);
				end else begin
					foreach (fired[k]) begin
						r      = fired[k];
						r.last = (k == fired.size() - 1);
						expected_q.push_back(r);
					end
				end
			end
		endfunction

		function void compare_field(string name, logic [TAG_W-1:0] want,
				logic [TAG_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		// compare one accepted result item with the oldest prediction
		function void check_rsp(rsp_item_t got);
			rsp_item_t want;
			rsp_count++;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: kind %0d slot %0d tag %0d last %0d",
					got.kind, got.slot, got.expired_tag, got.last);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("kind", TAG_W'(want.kind), TAG_W'(got.kind));
			compare_field("slot", TAG_W'(want.slot), TAG_W'(got.slot));
			compare_field("expired_tag", want.expired_tag, got.expired_tag);
			compare_field("last", TAG_W'(want.last), TAG_W'(got.last));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	localparam int LATENCY          = SLOTS + 2;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int HOLD_CYCLES      = 400;
	localparam int RANDOM_PER_PHASE = 125;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp;

	int send_idle_pct;
	int rsp_idle_pct;
	bit hold_req;

	timer_table_scoreboard sb = new();

	countdown_timer_slot_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor both channels on accepted items
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				sb.note_cmd(cmd);
			if (rsp_valid && !rsp_stall)
				sb.check_rsp(rsp);
		end
	end

	// watchdog: too long with no item moving on either side
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stall, plus a long hold-off on request
	initial begin
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
		end
	end

	function automatic cmd_item_t make_cmd(logic act, logic [SEC_W-1:0] secs,
			logic [TAG_W-1:0] t);
		cmd_item_t c;
		c.action  = act;
		c.seconds = secs;
		c.tag     = t;
		return c;
	endfunction

	// mostly short timeouts and small ticks so slots fill and expire often
	function automatic cmd_item_t random_cmd();
		cmd_item_t c;
		c.tag = TAG_W'($urandom);
		if ($urandom_range(99) < 58) begin
			c.action  = ACT_ADD;
			c.seconds = ($urandom_range(9) == 0) ? SEC_W'($urandom) : SEC_W'($urandom_range(40));
		end else begin
			c.action = ACT_TICK;
			case ($urandom_range(9))
				0: begin
					c.seconds = '0;
				end
				1: begin
					c.seconds = SEC_W'($urandom);
				end
				default: begin
					c.seconds = SEC_W'($urandom_range(12));
				end
			endcase
		end
		return c;
	endfunction

	// offer one item after a random gap, hold it until accepted
	task automatic send_cmd(input cmd_item_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	// stop sending and wait for every predicted result
	task automatic drain();
		cmd_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
	endtask

	task automatic run_phase(input int s_pct, input int r_pct, input bit hold);
		send_idle_pct = s_pct;
		rsp_idle_pct  = r_pct;
		if (hold)
			hold_req = 1'b1;
		repeat (RANDOM_PER_PHASE) send_cmd(random_cmd());
		drain();
	endtask

	// stimulus
	initial begin
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		send_idle_pct = 0;
		rsp_idle_pct  = 0;
		hold_req      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick on an empty table
		send_cmd(make_cmd(ACT_TICK, 16'd0, 8'h00));
		// zero timeout expires on a zero tick
		send_cmd(make_cmd(ACT_ADD, 16'd0, 8'hFF));
		send_cmd(make_cmd(ACT_TICK, 16'd0, 8'hFF));
		send_cmd(make_cmd(ACT_ADD, 16'hFFFF, 8'h00));
		send_cmd(make_cmd(ACT_ADD, 16'd5, 8'hA5));
		send_cmd(make_cmd(ACT_ADD, 16'd1, 8'h5A));
		// zero tick with nothing at zero
		send_cmd(make_cmd(ACT_TICK, 16'd0, 8'h00));
		// elapsed beyond remaining saturates
		send_cmd(make_cmd(ACT_TICK, 16'd3, 8'h00));
		// fill the table, then one add too many
		for (int i = 2; i < SLOTS; i++)
			send_cmd(make_cmd(ACT_ADD, SEC_W'(i * 7), TAG_W'(i * 17)));
		send_cmd(make_cmd(ACT_ADD, 16'd9, 8'h3C));
		// every slot expires in one tick
		send_cmd(make_cmd(ACT_TICK, 16'hFFFF, 8'hFF));
		drain();

		run_phase(17, 88, 1'b0);
		run_phase(88, 17, 1'b0);
		run_phase(0, 0, 1'b1);

		$display("Ran %0d items (%0d adds hit a full table), checked %0d results, %0d expiries.",
			sb.cmd_count, sb.full_count, sb.rsp_count, sb.expiry_count);
		$display("Idle mixes: heavy receiver stall, heavy sender gaps, none with a long hold-off.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ----- countdown_timer_slot_table.f -----
+incdir+rtl/core
rtl/core/ctst_pkg.sv
rtl/core/ctst_cell.sv
rtl/core/ctst_ctrl.sv
rtl/core/countdown_timer_slot_table.sv
dv/countdown_timer_slot_table_tb.sv
